### hdl/rfrc_pkg.sv
// ----------------------------------------------------------------------------
// rfrc_pkg: shared definitions for the RTU frame receive check
// Sizes, codes, register map and the types passed between the modules.
// ----------------------------------------------------------------------------
package rfrc_pkg;

   // Frame store size and the widths that follow from it.
   localparam int BUFFER_BYTES = 16;
   localparam int ADDR_W       = $clog2(BUFFER_BYTES);
   localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);

   // CRC-16 as used on the serial line: reflected polynomial, all-ones start.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam int          CRC_BITS = 8;

   localparam logic [7:0] BROADCAST_NODE = 8'h00;

   // Register reset values.
   localparam logic [7:0] SLAVE_ADDR_RESET = 8'd1;
   localparam logic [7:0] GAP_TICKS_RESET  = 8'd6;
   localparam logic [7:0] WD_RELOAD_RESET  = 8'd40;
   localparam logic [7:0] WD_COUNT_RESET   = 8'd40;

   // Register map: word index taken from the byte address.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
   localparam logic [1:0] REG_GAP_TICKS  = 2'd1;
   localparam logic [1:0] REG_WD_RELOAD  = 2'd2;

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_MS_TICK = 2'd1,
      OP_RELEASE = 2'd2,
      OP_WD_TICK = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_NONE     = 2'd0,
      VERDICT_ACCEPT   = 2'd1,
      VERDICT_CRC_BAD  = 2'd2,
      VERDICT_ADDR_BAD = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POST,
      ST_CRC_RD,
      ST_CRC_LOAD,
      ST_CRC_BIT,
      ST_CHECK,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic [7:0] slave_address;
      logic [7:0] gap_ticks;
      logic [7:0] watchdog_reload;
   } cfg_type;

   typedef struct packed {
      logic       init;
      logic       load;
      logic       step;
      logic [7:0] data;
   } crc_cmd_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  frame_byte;
      logic [5:0]  byte_index;
      logic        last_byte;
      logic        link_active;
      logic        holding;
   } rsp_type;

endpackage

### hdl/rfrc_ram.sv
// ----------------------------------------------------------------------------
// rfrc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rfrc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/rfrc_crc_unit.sv
// ----------------------------------------------------------------------------
// rfrc_crc_unit: bit-serial CRC-16 engine
// Folds in a byte on load and advances the reflected CRC one bit per step.
// ----------------------------------------------------------------------------
module rfrc_crc_unit (
   input  logic                 clock,
   input  rfrc_pkg::crc_cmd_type cmd,
   output logic [15:0]          crc
);
   import rfrc_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (cmd.init) begin
         crc_in = CRC_INIT;
      end else if (cmd.load) begin
         crc_in = crc_ff ^ {8'h00, cmd.data};
      end else if (cmd.step) begin
         crc_in = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

### hdl/rfrc_ctrl.sv
// ----------------------------------------------------------------------------
// rfrc_ctrl: receive sequencer
// Handles each transaction, drives the CRC pass over the store and emits the
// accepted frame through the result register.
// ----------------------------------------------------------------------------
module rfrc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  rfrc_pkg::cfg_type      cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rfrc_pkg::rsp_type      rsp,
   output rfrc_pkg::ram_req_type  ram_req,
   input  logic [7:0]             ram_rd_data,
   output rfrc_pkg::crc_cmd_type  crc_cmd,
   input  logic [15:0]            crc_value
);
   import rfrc_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        gap_ff, gap_in;
   logic [7:0]        wd_ff, wd_in;
   logic              link_ff, link_in;
   logic              hold_ff, hold_in;
   logic [7:0]        rx_m1_ff, rx_m1_in;
   logic [7:0]        rx_m2_ff, rx_m2_in;
   logic [7:0]        first_ff, first_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] body_ff, body_in;
   logic [2:0]        bit_ff, bit_in;
   verdict_type       pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              out_free;
   logic [CNT_W-1:0]  count_eff;
   logic [7:0]        gap_dec;
   logic              last_idx;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign count_eff = (gap_ff == 8'd0) ? '0 : count_ff;
   assign gap_dec   = (gap_ff != 8'd0) ? (gap_ff - 8'd1) : 8'd0;
   assign last_idx  = (idx_ff == (body_ff - ADDR_W'(1)));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      gap_in       = gap_ff;
      wd_in        = wd_ff;
      link_in      = link_ff;
      hold_in      = hold_ff;
      rx_m1_in     = rx_m1_ff;
      rx_m2_in     = rx_m2_ff;
      first_in     = first_ff;
      idx_in       = idx_ff;
      body_in      = body_ff;
      bit_in       = bit_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_req      = '0;
      crc_cmd      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in  = VERDICT_NONE;
               state_in = ST_POST;
               case (op_type'(req_op))
                  OP_BYTE: begin
                     if (!hold_ff) begin
                        gap_in   = cfg.gap_ticks;
                        rx_m1_in = req_rx_byte;
                        rx_m2_in = rx_m1_ff;
                        if (count_eff == '0) begin
                           first_in = req_rx_byte;
                        end
                        // Once full, the last two bytes live in the shadow
                        // registers only; the body entries stay as they are.
                        if (count_eff < CNT_W'(BUFFER_BYTES)) begin
                           ram_req.wr_en   = 1'b1;
                           ram_req.wr_addr = count_eff[ADDR_W-1:0];
                           ram_req.wr_data = req_rx_byte;
                           count_in        = count_eff + CNT_W'(1);
                        end else begin
                           count_in = count_eff;
                        end
                     end
                  end
                  OP_MS_TICK: begin
                     gap_in = gap_dec;
                     if (!hold_ff && gap_dec == 8'd0 && count_ff > CNT_W'(2)) begin
                        body_in      = ADDR_W'(count_ff - CNT_W'(2));
                        idx_in       = '0;
                        crc_cmd.init = 1'b1;
                        state_in     = ST_CRC_RD;
                     end
                  end
                  OP_RELEASE: begin
                     if (hold_ff) begin
                        hold_in  = 1'b0;
                        count_in = '0;
                     end
                  end
                  OP_WD_TICK: begin
                     if (wd_ff != 8'd0) begin
                        wd_in = wd_ff - 8'd1;
                     end else begin
                        link_in  = 1'b0;
                        count_in = '0;
                        gap_in   = 8'd0;
                        hold_in  = 1'b0;
                        wd_in    = cfg.watchdog_reload;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POST: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.verdict     = pend_ff;
               rsp_in.frame_byte  = 8'h00;
               rsp_in.byte_index  = 6'd0;
               rsp_in.last_byte   = 1'b0;
               rsp_in.link_active = link_ff;
               rsp_in.holding     = hold_ff;
               state_in           = ST_IDLE;
            end
         end
         ST_CRC_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = idx_ff;
            state_in        = ST_CRC_LOAD;
         end
         ST_CRC_LOAD: begin
            crc_cmd.load = 1'b1;
            crc_cmd.data = ram_rd_data;
            bit_in       = 3'd0;
            state_in     = ST_CRC_BIT;
         end
         ST_CRC_BIT: begin
            crc_cmd.step = 1'b1;
            bit_in       = bit_ff + 3'd1;
            if (bit_ff == 3'(CRC_BITS - 1)) begin
               if (last_idx) begin
                  state_in = ST_CHECK;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = ST_CRC_RD;
               end
            end
         end
         ST_CHECK: begin
            count_in = '0;
            if (crc_value != {rx_m1_ff, rx_m2_ff}) begin
               pend_in  = VERDICT_CRC_BAD;
               state_in = ST_POST;
            end else if (first_ff != cfg.slave_address && first_ff != BROADCAST_NODE) begin
               pend_in  = VERDICT_ADDR_BAD;
               state_in = ST_POST;
            end else begin
               link_in  = 1'b1;
               hold_in  = 1'b1;
               wd_in    = cfg.watchdog_reload;
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = idx_ff;
            state_in        = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.verdict     = VERDICT_ACCEPT;
               rsp_in.frame_byte  = ram_rd_data;
               rsp_in.byte_index  = 6'(idx_ff);
               rsp_in.last_byte   = last_idx;
               rsp_in.link_active = link_ff;
               rsp_in.holding     = hold_ff;
               if (last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         gap_ff       <= 8'd0;
         wd_ff        <= WD_COUNT_RESET;
         link_ff      <= 1'b0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         gap_ff       <= gap_in;
         wd_ff        <= wd_in;
         link_ff      <= link_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_m1_ff <= rx_m1_in;
      rx_m2_ff <= rx_m2_in;
      first_ff <= first_in;
      idx_ff   <= idx_in;
      body_ff  <= body_in;
      bit_ff   <= bit_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### hdl/rtu_frame_receive_check.sv
// ----------------------------------------------------------------------------
// rtu_frame_receive_check: serial-line slave frame receiver with CRC check
// Collects received bytes, closes a frame on inter-byte silence, checks the
// CRC-16 and the slave address, and hands a good frame out byte by byte.
// ----------------------------------------------------------------------------
// A transaction on the request channel is one event: a received byte, a
// millisecond tick, a release after the reply, or a slow watchdog tick. Every
// transaction produces exactly one result, except a millisecond tick that
// closes a good frame, which produces one result per frame byte (CRC
// excluded) and then blocks further byte reception until a release or a
// watchdog expiry. A simple event is accepted and updates state, then the
// result register is loaded once free. In a frame check each body byte is
// read from the store, registered, then folded in one bit per cycle by a
// single CRC engine; a compare state follows, then each emitted byte has a
// read and an output state on the store's single read port. The result
// register keeps the finished result while the consumer stalls. The frame
// store needs no clearing after reset; only written entries are ever read.
// ----------------------------------------------------------------------------
module rtu_frame_receive_check (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_op,
   input  logic [7:0]                      req_rx_byte,
   // Result channel.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_verdict,
   output logic [7:0]                      rsp_frame_byte,
   output logic [5:0]                      rsp_byte_index,
   output logic                            rsp_last_byte,
   output logic                            rsp_link_active,
   output logic                            rsp_holding,
   // Configuration port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rfrc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rfrc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rfrc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import rfrc_pkg::*;

   logic [7:0]  slave_addr_ff, slave_addr_in;
   logic [7:0]  gap_ticks_ff, gap_ticks_in;
   logic [7:0]  wd_reload_ff, wd_reload_in;

   logic        csr_write;
   logic [1:0]  csr_index;

   cfg_type     cfg;
   rsp_type     rsp;
   ram_req_type ram_req;
   logic [7:0]  ram_rd_data;
   crc_cmd_type crc_cmd;
   logic [15:0] crc_value;

   // The register file. The port never waits, so a write lands at the
   // access cycle. Writes to addresses past the last register are dropped.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      slave_addr_in = slave_addr_ff;
      gap_ticks_in  = gap_ticks_ff;
      wd_reload_in  = wd_reload_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SLAVE_ADDR: slave_addr_in = csr_pwdata[7:0];
            REG_GAP_TICKS:  gap_ticks_in  = csr_pwdata[7:0];
            REG_WD_RELOAD:  wd_reload_in  = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SLAVE_ADDR: csr_prdata = {24'h000000, slave_addr_ff};
         REG_GAP_TICKS:  csr_prdata = {24'h000000, gap_ticks_ff};
         REG_WD_RELOAD:  csr_prdata = {24'h000000, wd_reload_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= SLAVE_ADDR_RESET;
         gap_ticks_ff  <= GAP_TICKS_RESET;
         wd_reload_ff  <= WD_RELOAD_RESET;
      end else begin
         slave_addr_ff <= slave_addr_in;
         gap_ticks_ff  <= gap_ticks_in;
         wd_reload_ff  <= wd_reload_in;
      end
   end

   assign cfg.slave_address   = slave_addr_ff;
   assign cfg.gap_ticks       = gap_ticks_ff;
   assign cfg.watchdog_reload = wd_reload_ff;

   // Sequencer: owns all receive state and the result register.
   rfrc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .crc_cmd     (crc_cmd),
      .crc_value   (crc_value)
   );

   // Frame store. The last two bytes of a full frame are also kept in
   // shadow registers inside the sequencer, so the store never shifts.
   rfrc_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Bit-serial CRC engine.
   rfrc_crc_unit u_crc (
      .clock (clock),
      .cmd   (crc_cmd),
      .crc   (crc_value)
   );

   assign rsp_verdict     = rsp.verdict;
   assign rsp_frame_byte  = rsp.frame_byte;
   assign rsp_byte_index  = rsp.byte_index;
   assign rsp_last_byte   = rsp.last_byte;
   assign rsp_link_active = rsp.link_active;
   assign rsp_holding     = rsp.holding;

endmodule

### hdl/rfrc_checker.sv
// ----------------------------------------------------------------------------
// rfrc_checker: port-level assertions for the RTU frame receive check
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rfrc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [1:0]                      rsp_verdict,
   input logic [7:0]                      rsp_frame_byte,
   input logic [5:0]                      rsp_byte_index,
   input logic                            rsp_last_byte,
   input logic                            rsp_link_active,
   input logic                            rsp_holding
);
   import rfrc_pkg::*;

   // Each accepted transaction puts the block into a busy state that stalls requests.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while the previous one was still in work");

   // Only accepted frame bytes carry payload.
   a_payload_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != VERDICT_ACCEPT |->
         rsp_frame_byte == 8'h00 && rsp_byte_index == 6'd0 && !rsp_last_byte)
      else $error("payload fields set on a result without an accepted byte");

   // An accepted frame marks the link active and blocks reception.
   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_ACCEPT |-> rsp_link_active && rsp_holding)
      else $error("accepted frame byte without link and hold flags");

   // A stalled result stays put.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict)
         && $stable(rsp_frame_byte) && $stable(rsp_byte_index)
         && $stable(rsp_last_byte) && $stable(rsp_link_active) && $stable(rsp_holding))
      else $error("stalled result changed");

endmodule

bind rtu_frame_receive_check rfrc_checker u_rfrc_checker (.*);

### tb/rtu_frame_receive_check_tb.sv
// ----------------------------------------------------------------------------
// rtu_frame_receive_check_tb: self-checking bench for the RTU frame receiver
// Drives bytes, millisecond ticks, releases and watchdog ticks through the
// request channel. Each result transaction is checked field by field, in
// arrival order, against a behavioral copy of the receiver or a typed row.
// Register settings are swept between phases over the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtu_frame_receive_check_tb;
   import rfrc_pkg::*;

   // Generous ceiling on the run, far above the slowest legal schedule.
   localparam int CYCLE_LIMIT = 5000000;
   // Cycles allowed after the last result before a register write or the end.
   localparam int SETTLE_CYCLES = 20;
   // A register index just past the end of the map; writes to it are ignored.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   // Kinds of rows in the directed script. A typed row carries its expected
   // result in the row; a CRC row sends the CRC of the bytes that precede it
   // (low byte first), with the row's data XORed into the low byte.
   typedef enum logic [1:0] {
      ROW_PLAIN,
      ROW_TYPED,
      ROW_CRC
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      op_type       op;
      logic [7:0]   data;
      verdict_type  verdict;
      logic         link;
      logic         hold;
   } stim_row_type;

   localparam int SCRIPT_ROWS = 26;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_op      = OP_BYTE;
   logic [7:0]            req_rx_byte = 8'h00;

   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [1:0]            rsp_verdict;
   logic [7:0]            rsp_frame_byte;
   logic [5:0]            rsp_byte_index;
   logic                  rsp_last_byte;
   logic                  rsp_link_active;
   logic                  rsp_holding;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rtu_frame_receive_check dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_verdict     (rsp_verdict),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_link_active (rsp_link_active),
      .rsp_holding     (rsp_holding),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #6 clock = ~clock;

   // Mirror of the receiver: register copies and the frame state.
   logic [7:0] cfg_reg [3];
   logic [7:0] p_store [BUFFER_BYTES];
   int         p_count;
   logic [7:0] p_gap;
   logic [7:0] p_wd;
   logic       p_link;
   logic       p_hold;

   // Results caused by the transaction just accepted, and the queue of all
   // results still owed by the block, oldest first.
   rsp_type step_out [$];
   rsp_type rsp_due [$];

   int n_errors     = 0;
   int n_items      = 0;
   int n_checked    = 0;
   int n_frames_ok  = 0;
   int n_crc_drops  = 0;
   int n_addr_drops = 0;
   int n_wd_expiry  = 0;
   int cycle_count  = 0;

   int stall_run = 0;
   int calm_run  = 0;

   stim_row_type script [SCRIPT_ROWS];

   // Serial-line CRC-16, reflected polynomial, one byte folded in.
   function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void note_result(verdict_type v, logic [7:0] b, logic [5:0] idx,
                                       logic last);
      rsp_type r;
      r.verdict     = v;
      r.frame_byte  = b;
      r.byte_index  = idx;
      r.last_byte   = last;
      r.link_active = p_link;
      r.holding     = p_hold;
      step_out.push_back(r);
   endfunction

   // Advances the mirror by one event and leaves its results in step_out.
   function automatic void predict_event(op_type op, logic [7:0] b);
      logic [15:0] crc;
      logic [15:0] tail;
      int          body;
      bit          produced;
      step_out.delete();
      produced = 1'b0;
      case (op)
         OP_BYTE: begin
            // A byte is dropped while a good frame waits for its release.
            if (!p_hold) begin
               if (p_gap == 8'd0) p_count = 0;
               p_gap = cfg_reg[REG_GAP_TICKS];
               if (p_count >= BUFFER_BYTES) begin
                  // Full store: the CRC pair slides through the last two slots.
                  p_store[BUFFER_BYTES-2] = p_store[BUFFER_BYTES-1];
                  p_store[BUFFER_BYTES-1] = b;
               end else begin
                  p_store[p_count] = b;
                  p_count++;
               end
            end
         end
         OP_MS_TICK: begin
            if (p_gap != 8'd0) p_gap = p_gap - 8'd1;
            if (!p_hold && p_gap == 8'd0 && p_count > 2) begin
               body = p_count - 2;
               crc  = CRC_INIT;
               for (int i = 0; i < body; i++) crc = crc16_fold(crc, p_store[i]);
               tail     = {p_store[p_count-1], p_store[p_count-2]};
               p_count  = 0;
               produced = 1'b1;
               if (crc != tail) begin
                  n_crc_drops++;
                  note_result(VERDICT_CRC_BAD, 8'h00, 6'd0, 1'b0);
               end else if (p_store[0] != cfg_reg[REG_SLAVE_ADDR] &&
                            p_store[0] != BROADCAST_NODE) begin
                  n_addr_drops++;
                  note_result(VERDICT_ADDR_BAD, 8'h00, 6'd0, 1'b0);
               end else begin
                  p_link = 1'b1;
                  p_wd   = cfg_reg[REG_WD_RELOAD];
                  p_hold = 1'b1;
                  n_frames_ok++;
                  for (int i = 0; i < body; i++) begin
                     note_result(VERDICT_ACCEPT, p_store[i], 6'(i), i == body - 1);
                  end
               end
            end
         end
         OP_RELEASE: begin
            if (p_hold) begin
               p_hold  = 1'b0;
               p_count = 0;
            end
         end
         default: begin
            if (p_wd != 8'd0) begin
               p_wd = p_wd - 8'd1;
            end else begin
               // Watchdog expiry drops the link and starts reception afresh.
               n_wd_expiry++;
               p_link  = 1'b0;
               p_count = 0;
               p_gap   = 8'd0;
               p_hold  = 1'b0;
               p_wd    = cfg_reg[REG_WD_RELOAD];
            end
         end
      endcase
      if (!produced) note_result(VERDICT_NONE, 8'h00, 6'd0, 1'b0);
   endfunction

   // Presents one event on the request channel after a random idle gap and
   // waits for its handshake. Called and returns just after a falling edge.
   task automatic send_event(op_type op, logic [7:0] b, bit typed = 1'b0,
                             rsp_type typed_rsp = '0);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      // Bytes dropped while holding do not count as stimulus.
      if (!(op == OP_BYTE && p_hold)) n_items++;
      predict_event(op, b);
      if (typed) rsp_due.push_back(typed_rsp);
      else foreach (step_out[i]) rsp_due.push_back(step_out[i]);
      @(negedge clock);
   endtask

   // Stops sending and waits until the block owes nothing, then lets it settle.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One APB-style transfer: setup cycle, then access cycle until pready,
   // then the bus goes idle before the next transfer may begin.
   task automatic csr_access(bit wr, logic [1:0] idx, logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_registers();
      logic [31:0] rd;
      for (int i = 0; i < 3; i++) begin
         csr_access(1'b0, 2'(i), 32'h0, rd);
         if (rd[7:0] !== cfg_reg[i]) begin
            n_errors++;
            $display("%0t ns: register %0d read back: expected %02h, actual %02h",
                     $time, i, cfg_reg[i], rd[7:0]);
         end
      end
   endtask

   // Writes all three registers, pokes the unused index, and reads back.
   task automatic set_config(logic [7:0] slave, logic [7:0] gap, logic [7:0] reload);
      logic [31:0] rd;
      cfg_reg[REG_SLAVE_ADDR] = slave;
      cfg_reg[REG_GAP_TICKS]  = gap;
      cfg_reg[REG_WD_RELOAD]  = reload;
      for (int i = 0; i < 3; i++) csr_access(1'b1, 2'(i), {24'h0, cfg_reg[i]}, rd);
      csr_access(1'b1, REG_UNUSED, $urandom, rd);
      check_registers();
   endtask

   // Random traffic for one register setting. Most of it is well-formed
   // frames with random content, closed by a silent gap and released; the
   // rest is loose events, watchdog bursts and frames with no valid CRC.
   task automatic run_phase(int budget);
      logic [7:0]  frame [$];
      logic [15:0] crc;
      int          stop_at;
      int          half;
      int          kind;
      int          k;
      int          body;
      int          closing;
      bit          paused;
      stop_at = n_items + budget;
      half    = n_items + budget / 2;
      paused  = 1'b0;
      while (n_items < stop_at) begin
         // Once per phase the sender holds off until every result is in.
         if (!paused && n_items >= half) begin
            paused = 1'b1;
            wait_for_results();
         end
         closing = (cfg_reg[REG_GAP_TICKS] == 8'd0) ? 1 : int'(cfg_reg[REG_GAP_TICKS]);
         kind = $urandom_range(0, 99);
         if (kind < 65) begin
            frame.delete();
            k = $urandom_range(0, 99);
            if (k < 60) frame.push_back(cfg_reg[REG_SLAVE_ADDR]);
            else if (k < 75) frame.push_back(BROADCAST_NODE);
            else frame.push_back(8'($urandom));
            k = $urandom_range(0, 99);
            if (k < 60) body = $urandom_range(1, 6);
            else if (k < 90) body = $urandom_range(7, BUFFER_BYTES - 3);
            else body = BUFFER_BYTES - 2;
            while (frame.size() < body) frame.push_back(8'($urandom));
            crc = CRC_INIT;
            foreach (frame[i]) crc = crc16_fold(crc, frame[i]);
            if ($urandom_range(0, 99) < 12) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            // Overlong frame: extra bytes push through the last two slots.
            if (body == BUFFER_BYTES - 2 && $urandom_range(0, 1) == 1) begin
               repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
            end
            frame.push_back(crc[7:0]);
            frame.push_back(crc[15:8]);
            foreach (frame[i]) begin
               send_event(OP_BYTE, frame[i]);
               // A tick inside the frame that does not yet end the gap.
               if (cfg_reg[REG_GAP_TICKS] >= 8'd2 && $urandom_range(0, 9) == 0) begin
                  send_event(OP_MS_TICK, 8'($urandom));
               end
            end
            repeat (closing) send_event(OP_MS_TICK, 8'($urandom));
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3)) begin
                  send_event(op_type'(2'($urandom_range(0, 1))), 8'($urandom));
               end
            end
            send_event(OP_RELEASE, 8'($urandom));
         end else if (kind < 82) begin
            repeat ($urandom_range(1, 6)) begin
               send_event(op_type'(2'($urandom_range(0, 3))), 8'($urandom));
            end
            if ($urandom_range(0, 1) == 1) begin
               repeat (closing) send_event(OP_MS_TICK, 8'($urandom));
            end
         end else if (kind < 90) begin
            repeat ($urandom_range(1, 8)) send_event(OP_WD_TICK, 8'($urandom));
         end else begin
            // Short or corrupt frame; one or two bytes are never checked.
            repeat ($urandom_range(1, 8)) send_event(OP_BYTE, 8'($urandom));
            repeat (closing) send_event(OP_MS_TICK, 8'($urandom));
            send_event(OP_RELEASE, 8'($urandom));
         end
      end
   endtask

   // Result side stalls: calm stretches, short stalls, and now and then a
   // long one, so that stalls land on every stage of the block's work.
   always @(negedge clock) begin
      int r;
      if (stall_run > 0) begin
         stall_run--;
         rsp_stall <= 1'b1;
      end else if (calm_run > 0) begin
         calm_run--;
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            calm_run = $urandom_range(1, 40);
            rsp_stall <= 1'b0;
         end else if (r < 94) begin
            stall_run = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            stall_run = $urandom_range(10, 40);
            rsp_stall <= 1'b1;
         end
      end
   end

   // Every result transaction is matched against the oldest expectation.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.verdict     = verdict_type'(rsp_verdict);
         got.frame_byte  = rsp_frame_byte;
         got.byte_index  = rsp_byte_index;
         got.last_byte   = rsp_last_byte;
         got.link_active = rsp_link_active;
         got.holding     = rsp_holding;
         if (rsp_due.size() == 0) begin
            n_errors++;
            $display("%0t ns: unexpected result: verdict %0d byte %02h index %0d last %0d",
                     $time, got.verdict, got.frame_byte, got.byte_index, got.last_byte);
         end else begin
            want = rsp_due.pop_front();
            n_checked++;
            if (got !== want) begin
               n_errors++;
               $display("%0t ns: mismatch: expected verdict %0d byte %02h index %0d last %0d link %0d hold %0d",
                        $time, want.verdict, want.frame_byte, want.byte_index,
                        want.last_byte, want.link_active, want.holding);
               $display("%0t ns:           actual verdict %0d byte %02h index %0d last %0d link %0d hold %0d",
                        $time, got.verdict, got.frame_byte, got.byte_index,
                        got.last_byte, got.link_active, got.holding);
            end
         end
      end
   end

   // Watchdog on the bench itself: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout with %0d results still owed", $time, rsp_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      rsp_type      typed_rsp;
      logic [15:0]  script_crc;

      // The directed script runs with a one-tick gap, so each frame closes
      // on the first silent tick. Error verdicts, the plain events right after
      // reset and the second release carry their results in the row.
      script = '{
         '{ROW_TYPED, OP_RELEASE, 8'h00, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_TYPED, OP_MS_TICK, 8'hFF, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_TYPED, OP_WD_TICK, 8'hAA, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_TYPED, OP_BYTE,    8'h00, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_TYPED, OP_BYTE,    8'hFF, VERDICT_NONE,     1'b0, 1'b0},
         // Gap ends with only two bytes held: no check is made.
         '{ROW_TYPED, OP_MS_TICK, 8'h00, VERDICT_NONE,     1'b0, 1'b0},
         // Good frame addressed to this node.
         '{ROW_PLAIN, OP_BYTE,    8'h01, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_PLAIN, OP_BYTE,    8'hFF, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_PLAIN, OP_BYTE,    8'h00, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_CRC,   OP_BYTE,    8'h00, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_PLAIN, OP_MS_TICK, 8'h00, VERDICT_NONE,     1'b0, 1'b0},
         // While holding, a byte is dropped and a tick makes no check.
         '{ROW_PLAIN, OP_BYTE,    8'h5A, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_PLAIN, OP_MS_TICK, 8'h3C, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_PLAIN, OP_RELEASE, 8'h00, VERDICT_NONE,     1'b0, 1'b0},
         // A second release with nothing held does nothing.
         '{ROW_TYPED, OP_RELEASE, 8'hFF, VERDICT_NONE,     1'b1, 1'b0},
         // Valid CRC but a foreign node number.
         '{ROW_PLAIN, OP_BYTE,    8'h07, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_CRC,   OP_BYTE,    8'h00, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_TYPED, OP_MS_TICK, 8'h00, VERDICT_ADDR_BAD, 1'b1, 1'b0},
         // One CRC bit flipped.
         '{ROW_PLAIN, OP_BYTE,    8'h00, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_CRC,   OP_BYTE,    8'h01, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_TYPED, OP_MS_TICK, 8'h00, VERDICT_CRC_BAD,  1'b1, 1'b0},
         // Broadcast frame is accepted and held like an addressed one.
         '{ROW_PLAIN, OP_BYTE,    8'h00, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_PLAIN, OP_BYTE,    8'h06, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_CRC,   OP_BYTE,    8'h00, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_PLAIN, OP_MS_TICK, 8'h00, VERDICT_NONE,     1'b0, 1'b0},
         '{ROW_PLAIN, OP_RELEASE, 8'h00, VERDICT_NONE,     1'b0, 1'b0}
      };

      // Mirror state after reset. The frame store starts unknown in the
      // block; only entries already written are ever read.
      cfg_reg[REG_SLAVE_ADDR] = SLAVE_ADDR_RESET;
      cfg_reg[REG_GAP_TICKS]  = GAP_TICKS_RESET;
      cfg_reg[REG_WD_RELOAD]  = WD_RELOAD_RESET;
      foreach (p_store[i]) p_store[i] = 8'h00;
      p_count = 0;
      p_gap   = 8'd0;
      p_wd    = WD_COUNT_RESET;
      p_link  = 1'b0;
      p_hold  = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register reset values first, then a short gap for the script.
      check_registers();
      set_config(SLAVE_ADDR_RESET, 8'd1, WD_RELOAD_RESET);

      script_crc = CRC_INIT;
      foreach (script[r]) begin
         row = script[r];
         typed_rsp.verdict     = row.verdict;
         typed_rsp.frame_byte  = 8'h00;
         typed_rsp.byte_index  = 6'd0;
         typed_rsp.last_byte   = 1'b0;
         typed_rsp.link_active = row.link;
         typed_rsp.holding     = row.hold;
         if (row.kind == ROW_CRC) begin
            send_event(OP_BYTE, script_crc[7:0] ^ row.data);
            send_event(OP_BYTE, script_crc[15:8]);
            script_crc = CRC_INIT;
         end else begin
            send_event(row.op, row.data, row.kind == ROW_TYPED, typed_rsp);
            if (row.op == OP_BYTE) script_crc = crc16_fold(script_crc, row.data);
            else script_crc = CRC_INIT;
         end
      end
      wait_for_results();

      // Random phases over a sweep of settings, extremes included: a
      // watchdog that expires on every tick, a zero gap that keeps only
      // single bytes, and the longest gap, where a single frame closed by
      // its silent ticks fills the whole phase.
      set_config(SLAVE_ADDR_RESET, GAP_TICKS_RESET, WD_RELOAD_RESET);
      run_phase(50);
      wait_for_results();
      set_config(8'hFF, 8'd1, 8'd0);
      run_phase(60);
      wait_for_results();
      set_config(8'h00, 8'd0, 8'hFF);
      run_phase(20);
      wait_for_results();
      set_config(8'hA5, 8'hFF, 8'd2);
      run_phase(240);
      wait_for_results();
      set_config(8'h37, 8'd2, 8'd7);
      run_phase(40);
      wait_for_results();

      if (rsp_due.size() != 0) begin
         n_errors++;
         $display("%0t ns: %0d expected results never arrived", $time, rsp_due.size());
      end

      $display("Run covered %0d events and %0d checked results over six settings.",
               n_items, n_checked);
      $display("Frames: %0d accepted, %0d CRC drops, %0d address drops; %0d watchdog expiries.",
               n_frames_ok, n_crc_drops, n_addr_drops, n_wd_expiry);
      if (n_errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
